// ===== hdl/gro_pkg.sv =====
`timescale 1ns / 1ps
package gro_pkg;

    localparam int GRO_MAX_COLS = 8;
    localparam int GRO_MAX_ROWS = 8;

    localparam logic [3:0] UPC_IDLE  = 4'd0;
    localparam logic [3:0] UPC_DISP  = 4'd1;
    localparam logic [3:0] UPC_CHK   = 4'd2;
    localparam logic [3:0] UPC_SCAN  = 4'd3;
    localparam logic [3:0] UPC_DEC   = 4'd4;
    localparam logic [3:0] UPC_MARK  = 4'd5;
    localparam logic [3:0] UPC_PLACE = 4'd6;
    localparam logic [3:0] UPC_SINIT = 4'd7;
    localparam logic [3:0] UPC_SCELL = 4'd8;
    localparam logic [3:0] UPC_SEND  = 4'd9;

    localparam logic [0:0] CFG_GRID_COLS = 1'd0;
    localparam logic [0:0] CFG_GRID_ROWS = 1'd1;

    typedef enum logic [2:0] {
        COND_NEXT,
        COND_JUMP,
        COND_WAIT_START,
        COND_FINISH,
        COND_OOB,
        COND_MORE_ROWS,
        COND_HIT,
        COND_MORE_CELLS
    } t_cond;

    typedef enum logic [1:0] {
        EMIT_NONE,
        EMIT_ECHO,
        EMIT_PEND,
        EMIT_FINAL
    } t_emit;

    typedef enum logic [1:0] {
        ROW_HOLD,
        ROW_LOAD_Y,
        ROW_INC
    } t_row_op;

    typedef enum logic [2:0] {
        ST_PLACED,
        ST_OVERLAP,
        ST_OOB,
        ST_FREE,
        ST_EMPTY
    } t_status;

    typedef struct packed {
        t_cond      cond;
        logic [3:0] target;
        t_emit      emit;
        t_status    status;
        t_row_op    row_op;
        logic       latch;
        logic       hit_clr;
        logic       hit_acc;
        logic       mark;
        logic       sweep_init;
        logic       sweep_step;
        logic       sweep_end;
    } t_gro_uword;

    typedef struct packed {
        t_gro_uword w;
        logic       taken;
    } t_gro_ctl;

    typedef struct packed {
        logic start;
        logic finish;
        logic oob;
        logic more_rows;
        logic hit;
        logic more_cells;
    } t_gro_flags;

    function automatic t_gro_uword gro_rom(input logic [3:0] upc);
        t_gro_uword w;
        w = '{cond: COND_NEXT, target: UPC_IDLE, emit: EMIT_NONE, status: ST_PLACED,
              row_op: ROW_HOLD, default: 1'b0};
        case (upc)
            UPC_IDLE: begin
                w.cond   = COND_WAIT_START;
                w.target = UPC_IDLE;
                w.latch  = 1'b1;
            end
            UPC_DISP: begin
                w.cond   = COND_FINISH;
                w.target = UPC_SINIT;
                w.row_op = ROW_LOAD_Y;
            end
            UPC_CHK: begin
                w.cond    = COND_OOB;
                w.target  = UPC_IDLE;
                w.emit    = EMIT_ECHO;
                w.status  = ST_OOB;
                w.hit_clr = 1'b1;
            end
            UPC_SCAN: begin
                w.cond    = COND_MORE_ROWS;
                w.target  = UPC_SCAN;
                w.row_op  = ROW_INC;
                w.hit_acc = 1'b1;
            end
            UPC_DEC: begin
                w.cond   = COND_HIT;
                w.target = UPC_IDLE;
                w.emit   = EMIT_ECHO;
                w.status = ST_OVERLAP;
                w.row_op = ROW_LOAD_Y;
            end
            UPC_MARK: begin
                w.cond   = COND_MORE_ROWS;
                w.target = UPC_MARK;
                w.row_op = ROW_INC;
                w.mark   = 1'b1;
            end
            UPC_PLACE: begin
                w.cond   = COND_JUMP;
                w.target = UPC_IDLE;
                w.emit   = EMIT_ECHO;
                w.status = ST_PLACED;
            end
            UPC_SINIT: begin
                w.sweep_init = 1'b1;
            end
            UPC_SCELL: begin
                w.cond       = COND_MORE_CELLS;
                w.target     = UPC_SCELL;
                w.emit       = EMIT_PEND;
                w.sweep_step = 1'b1;
            end
            UPC_SEND: begin
                w.cond      = COND_JUMP;
                w.target    = UPC_IDLE;
                w.emit      = EMIT_FINAL;
                w.sweep_end = 1'b1;
            end
            default: begin
                w.cond   = COND_JUMP;
                w.target = UPC_IDLE;
            end
        endcase
        return w;
    endfunction

endpackage

// ===== hdl/grid_rectangle_occupancy_allocator.sv =====
`timescale 1ns / 1ps
// Rectangle allocator over an occupancy map of up to 8 x 8 cells.
// Command channel: an item is taken when start is high and busy is low.
// action 0 proposes a rectangle; exactly one result beat follows with
// status placed, overlap or out of bounds and last set.
// action 1 sweeps: one beat per free cell of the configured grid, columns
// outer and rows inner, last on the final one, or a single empty-sweep
// beat; the whole map is then cleared.
// Result beats show on the output ports for one cycle with o_valid high;
// the receiver cannot stall them.
// The microcode steps one map row or cell per cycle: a propose checks the
// bounds and ends if out of bounds, scans the rectangle's rows and ends on
// overlap, else marks those rows and reports placed; a sweep visits each
// cell of the configured grid, then sends the final beat. A result beat is
// registered and appears in the cycle after the step that makes it.
// Config: i_cfg_we writes grid_cols (index 0) or grid_rows (index 1);
// values are clamped to 1..8. Write only while busy is low.
// Reset: grid 8 x 8, map all free, sequencer idle, no beat pending.
module grid_rectangle_occupancy_allocator (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    output logic       busy,
    input  logic       i_action,
    input  logic [2:0] i_rect_col,
    input  logic [2:0] i_rect_row,
    input  logic [3:0] i_rect_width,
    input  logic [3:0] i_rect_height,
    input  logic       i_cfg_we,
    input  logic [0:0] i_cfg_idx,
    input  logic [3:0] i_cfg_data,
    output logic       o_valid,
    output logic [2:0] o_cell_col,
    output logic [2:0] o_cell_row,
    output logic [3:0] o_span_width,
    output logic [3:0] o_span_height,
    output logic [2:0] o_status,
    output logic       o_last
);
    import gro_pkg::*;

    logic [3:0] r_grid_cols, r_grid_rows;
    logic [3:0] cols, rows;
    t_gro_ctl   ctl;
    t_gro_flags flags;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_cols <= 4'(GRO_MAX_COLS);
            r_grid_rows <= 4'(GRO_MAX_ROWS);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_GRID_COLS: r_grid_cols <= i_cfg_data;
                CFG_GRID_ROWS: r_grid_rows <= i_cfg_data;
                default:       r_grid_cols <= r_grid_cols;
            endcase
        end
    end

    always_comb begin
        if (r_grid_cols == 4'd0) begin
            cols = 4'd1;
        end else if (r_grid_cols > 4'(GRO_MAX_COLS)) begin
            cols = 4'(GRO_MAX_COLS);
        end else begin
            cols = r_grid_cols;
        end
        if (r_grid_rows == 4'd0) begin
            rows = 4'd1;
        end else if (r_grid_rows > 4'(GRO_MAX_ROWS)) begin
            rows = 4'(GRO_MAX_ROWS);
        end else begin
            rows = r_grid_rows;
        end
    end

    gro_useq u_useq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_flags (flags),
        .o_ctl   (ctl),
        .o_busy  (busy)
    );

    gro_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctl         (ctl),
        .i_start       (start),
        .i_action      (i_action),
        .i_rect_col    (i_rect_col),
        .i_rect_row    (i_rect_row),
        .i_rect_width  (i_rect_width),
        .i_rect_height (i_rect_height),
        .i_cols        (cols),
        .i_rows        (rows),
        .o_flags       (flags),
        .o_valid       (o_valid),
        .o_cell_col    (o_cell_col),
        .o_cell_row    (o_cell_row),
        .o_span_width  (o_span_width),
        .o_span_height (o_span_height),
        .o_status      (o_status),
        .o_last        (o_last)
    );

endmodule

// ===== hdl/gro_useq.sv =====
`timescale 1ns / 1ps
module gro_useq (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  gro_pkg::t_gro_flags i_flags,
    output gro_pkg::t_gro_ctl   o_ctl,
    output logic                o_busy
);
    import gro_pkg::*;

    logic [3:0] r_upc;
    logic [3:0] n_upc;
    t_gro_uword uw;
    logic       taken;

    always_comb begin
        uw = gro_rom(r_upc);
        case (uw.cond)
            COND_NEXT:       taken = 1'b0;
            COND_JUMP:       taken = 1'b1;
            COND_WAIT_START: taken = !i_flags.start;
            COND_FINISH:     taken = i_flags.finish;
            COND_OOB:        taken = i_flags.oob;
            COND_MORE_ROWS:  taken = i_flags.more_rows;
            COND_HIT:        taken = i_flags.hit;
            COND_MORE_CELLS: taken = i_flags.more_cells;
            default:         taken = 1'b1;
        endcase
        n_upc = taken ? uw.target : r_upc + 4'd1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upc <= UPC_IDLE;
        end else begin
            r_upc <= n_upc;
        end
    end

    assign o_ctl  = '{w: uw, taken: taken};
    assign o_busy = (r_upc != UPC_IDLE);

`ifndef SYNTH
    a_upc_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_upc <= UPC_SEND)
        else $error("sequencer left its program");

    a_dispatch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_upc == UPC_IDLE) && i_flags.start |=> r_upc == UPC_DISP)
        else $error("accepted beat not dispatched");

    a_send_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_upc == UPC_SEND) |=> r_upc == UPC_IDLE)
        else $error("sweep end did not return to idle");
`endif
endmodule

// ===== hdl/gro_dp.sv =====
`timescale 1ns / 1ps
module gro_dp (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  gro_pkg::t_gro_ctl   i_ctl,
    input  logic                i_start,
    input  logic                i_action,
    input  logic [2:0]          i_rect_col,
    input  logic [2:0]          i_rect_row,
    input  logic [3:0]          i_rect_width,
    input  logic [3:0]          i_rect_height,
    input  logic [3:0]          i_cols,
    input  logic [3:0]          i_rows,
    output gro_pkg::t_gro_flags o_flags,
    output logic                o_valid,
    output logic [2:0]          o_cell_col,
    output logic [2:0]          o_cell_row,
    output logic [3:0]          o_span_width,
    output logic [3:0]          o_span_height,
    output logic [2:0]          o_status,
    output logic                o_last
);
    import gro_pkg::*;

    logic [GRO_MAX_COLS-1:0] r_occ [GRO_MAX_ROWS];
    logic       r_act;
    logic [2:0] r_x, r_y;
    logic [3:0] r_w, r_h;
    logic [2:0] r_row, r_col;
    logic       r_hit;
    logic       r_pend_vld;
    logic [2:0] r_pend_col, r_pend_row;
    logic       r_valid;
    logic [2:0] r_o_col, r_o_row, r_o_status;
    logic [3:0] r_o_w, r_o_h;
    logic       r_o_last;

    logic [GRO_MAX_COLS-1:0] row_bits, mask;
    logic       hit_now, cell_free, oob, last_row, last_col;
    logic [4:0] yh;
    logic       n_valid, n_last;
    logic [2:0] n_col, n_row, n_status;
    logic [3:0] n_w, n_h;
    logic       any_occ;

    always_comb begin
        row_bits  = r_occ[r_row];
        mask      = GRO_MAX_COLS'(((16'd1 << r_w) - 16'd1) << r_x);
        hit_now   = |(row_bits & mask);
        cell_free = !row_bits[r_col];
        yh        = {2'b0, r_y} + {1'b0, r_h};
        oob       = (r_w == 4'd0) || (r_h == 4'd0)
                    || (({2'b0, r_x} + {1'b0, r_w}) > {1'b0, i_cols})
                    || (yh > {1'b0, i_rows});
        last_row  = ({1'b0, r_row} == i_rows - 4'd1);
        last_col  = ({1'b0, r_col} == i_cols - 4'd1);
        any_occ   = 1'b0;
        for (int i = 0; i < GRO_MAX_ROWS; i++) begin
            any_occ = any_occ | (|r_occ[i]);
        end
    end

    assign o_flags = '{start:      i_start,
                       finish:     r_act,
                       oob:        oob,
                       more_rows:  (({2'b0, r_row} + 5'd1) != yh),
                       hit:        r_hit,
                       more_cells: !(last_row && last_col)};

    always_comb begin
        n_valid  = 1'b0;
        n_col    = r_x;
        n_row    = r_y;
        n_w      = r_w;
        n_h      = r_h;
        n_status = i_ctl.w.status;
        n_last   = 1'b1;
        case (i_ctl.w.emit)
            EMIT_ECHO: begin
                n_valid = i_ctl.taken;
            end
            EMIT_PEND: begin
                n_valid  = cell_free && r_pend_vld;
                n_col    = r_pend_col;
                n_row    = r_pend_row;
                n_w      = 4'd1;
                n_h      = 4'd1;
                n_status = ST_FREE;
                n_last   = 1'b0;
            end
            EMIT_FINAL: begin
                n_valid = 1'b1;
                if (r_pend_vld) begin
                    n_col    = r_pend_col;
                    n_row    = r_pend_row;
                    n_w      = 4'd1;
                    n_h      = 4'd1;
                    n_status = ST_FREE;
                end else begin
                    n_col    = 3'd0;
                    n_row    = 3'd0;
                    n_w      = 4'd0;
                    n_h      = 4'd0;
                    n_status = ST_EMPTY;
                end
            end
            default: begin
                n_valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= 1'b0;
            r_pend_vld <= 1'b0;
            for (int i = 0; i < GRO_MAX_ROWS; i++) begin
                r_occ[i] <= '0;
            end
        end else begin
            r_valid <= n_valid;
            if (i_ctl.w.sweep_init) begin
                r_pend_vld <= 1'b0;
            end else if (i_ctl.w.sweep_step && cell_free) begin
                r_pend_vld <= 1'b1;
            end
            if (i_ctl.w.mark) begin
                r_occ[r_row] <= row_bits | mask;
            end
            if (i_ctl.w.sweep_end) begin
                for (int i = 0; i < GRO_MAX_ROWS; i++) begin
                    r_occ[i] <= '0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.w.latch) begin
            r_act <= i_action;
            r_x   <= i_rect_col;
            r_y   <= i_rect_row;
            r_w   <= i_rect_width;
            r_h   <= i_rect_height;
        end
        if (i_ctl.w.sweep_init) begin
            r_row <= 3'd0;
        end else if (i_ctl.w.sweep_step) begin
            r_row <= last_row ? 3'd0 : r_row + 3'd1;
        end else begin
            case (i_ctl.w.row_op)
                ROW_LOAD_Y: r_row <= r_y;
                ROW_INC:    r_row <= r_row + 3'd1;
                default:    r_row <= r_row;
            endcase
        end
        if (i_ctl.w.hit_clr) begin
            r_hit <= 1'b0;
        end else if (i_ctl.w.hit_acc) begin
            r_hit <= r_hit | hit_now;
        end
        if (i_ctl.w.sweep_init) begin
            r_col <= 3'd0;
        end else if (i_ctl.w.sweep_step) begin
            if (cell_free) begin
                r_pend_col <= r_col;
                r_pend_row <= r_row;
            end
            if (last_row) begin
                r_col <= r_col + 3'd1;
            end
        end
        r_o_col    <= n_col;
        r_o_row    <= n_row;
        r_o_w      <= n_w;
        r_o_h      <= n_h;
        r_o_status <= n_status;
        r_o_last   <= n_last;
    end

    assign o_valid       = r_valid;
    assign o_cell_col    = r_o_col;
    assign o_cell_row    = r_o_row;
    assign o_span_width  = r_o_w;
    assign o_span_height = r_o_h;
    assign o_status      = r_o_status;
    assign o_last        = r_o_last;

`ifndef SYNTH
    a_clear_after_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.w.sweep_end |=> !any_occ)
        else $error("map not cleared after sweep");

    a_placed_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && (r_o_status == ST_PLACED || r_o_status == ST_OVERLAP
                    || r_o_status == ST_OOB || r_o_status == ST_EMPTY) |-> r_o_last)
        else $error("single-result beat without last");

    a_free_unit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && (r_o_status == ST_FREE) |-> (r_o_w == 4'd1) && (r_o_h == 4'd1))
        else $error("free cell beat not a unit rectangle");
`endif
endmodule

// ===== dv/grid_rectangle_occupancy_checker.sv =====
`timescale 1ns / 1ps
module grid_rectangle_occupancy_checker
    import gro_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_start,
    input  logic       i_busy,
    input  logic       i_sweep,
    input  logic [2:0] i_rect_col,
    input  logic [2:0] i_rect_row,
    input  logic [3:0] i_rect_width,
    input  logic [3:0] i_rect_height,
    input  logic       i_cfg_we,
    input  logic [0:0] i_cfg_idx,
    input  logic [3:0] i_cfg_data,
    input  logic       i_valid,
    input  logic [2:0] i_cell_col,
    input  logic [2:0] i_cell_row,
    input  logic [3:0] i_span_width,
    input  logic [3:0] i_span_height,
    input  logic [2:0] i_status,
    input  logic       i_last,
    output int         o_miscompares,
    output int         o_replies_due
);

    typedef struct packed {
        logic [2:0] col;
        logic [2:0] row;
        logic [3:0] w;
        logic [3:0] h;
        t_status    status;
        logic       last;
    } t_reply;

    logic [3:0] grid_cols;
    logic [3:0] grid_rows;
    logic [7:0] occ_map [GRO_MAX_ROWS];
    t_reply     reply_fifo [$];
    int         bad_beats = 0;

    function automatic int usable_span(input logic [3:0] v, input int limit);
        if (v == 4'd0) return 1;
        if (int'(v) > limit) return limit;
        return int'(v);
    endfunction

    task automatic queue_reply(input t_reply b);
        reply_fifo = {reply_fifo, b};
    endtask

    task automatic occupy_or_sweep(input logic sweep, input logic [2:0] x, input logic [2:0] y,
                                   input logic [3:0] w, input logic [3:0] h);
        int         ncols;
        int         nrows;
        int         c;
        int         r;
        int         first;
        int         span;
        logic [7:0] span_mask;
        logic       overlap;
        t_reply     beat;
        ncols = usable_span(grid_cols, GRO_MAX_COLS);
        nrows = usable_span(grid_rows, GRO_MAX_ROWS);
        if (!sweep) begin
            beat = '{x, y, w, h, ST_PLACED, 1'b1};
            if (w == 4'd0 || h == 4'd0 || int'(x) + int'(w) > ncols ||
                int'(y) + int'(h) > nrows) begin
                beat.status = ST_OOB;
            end else begin
                span = ((1 << int'(w)) - 1) << int'(x);
                span_mask = span[7:0];
                overlap = 1'b0;
                for (r = int'(y); r < int'(y) + int'(h); r++) begin
                    if ((occ_map[r] & span_mask) != 8'd0) overlap = 1'b1;
                end
                if (overlap) begin
                    beat.status = ST_OVERLAP;
                end else begin
                    for (r = int'(y); r < int'(y) + int'(h); r++) begin
                        occ_map[r] = occ_map[r] | span_mask;
                    end
                end
            end
            queue_reply(beat);
        end else begin
            first = reply_fifo.size();
            for (c = 0; c < ncols; c++) begin
                for (r = 0; r < nrows; r++) begin
                    if (!occ_map[r][c]) begin
                        queue_reply('{3'(c), 3'(r), 4'd1, 4'd1, ST_FREE, 1'b0});
                    end
                end
            end
            if (reply_fifo.size() == first) begin
                queue_reply('{3'd0, 3'd0, 4'd0, 4'd0, ST_EMPTY, 1'b1});
            end else begin
                reply_fifo[reply_fifo.size() - 1].last = 1'b1;
            end
            for (r = 0; r < GRO_MAX_ROWS; r++) occ_map[r] = 8'd0;
        end
    endtask

    always @(posedge i_clk) begin
        t_reply got;
        t_reply want;
        if (!i_rst_n) begin
            grid_cols = 4'd8;
            grid_rows = 4'd8;
            for (int r = 0; r < GRO_MAX_ROWS; r++) occ_map[r] = 8'd0;
            reply_fifo.delete();
        end else begin
            if (i_valid) begin
                got = '{i_cell_col, i_cell_row, i_span_width, i_span_height,
                        t_status'(i_status), i_last};
                if (reply_fifo.size() == 0) begin
                    $display("%0t: stray beat, expected none, actual col %0d row %0d w %0d h %0d",
                             $time, got.col, got.row, got.w, got.h,
                             " status %0d last %0d", got.status, got.last);
                    bad_beats++;
                end else begin
                    want = reply_fifo.pop_front();
                    if (got !== want) begin
                        $display("%0t: wrong beat, expected col %0d row %0d w %0d h %0d",
                                 $time, want.col, want.row, want.w, want.h,
                                 " status %0d last %0d, actual col %0d row %0d w %0d h %0d",
                                 want.status, want.last, got.col, got.row, got.w, got.h,
                                 " status %0d last %0d", got.status, got.last);
                        bad_beats++;
                    end
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_GRID_COLS: grid_cols = i_cfg_data;
                    CFG_GRID_ROWS: grid_rows = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_start && !i_busy) begin
                occupy_or_sweep(i_sweep, i_rect_col, i_rect_row, i_rect_width, i_rect_height);
            end
        end
        o_miscompares <= bad_beats;
        o_replies_due <= reply_fifo.size();
    end

endmodule

// ===== dv/tb_grid_rectangle_occupancy_allocator.sv =====
`timescale 1ns / 1ps
module tb_grid_rectangle_occupancy_allocator;
    import gro_pkg::*;

    localparam logic ACT_PROPOSE    = 1'b0;
    localparam logic ACT_FINISH     = 1'b1;
    localparam int   WATCHDOG_LIMIT = 3000;
    localparam int   N_PHASES       = 10;
    localparam int   PHASE_ITEMS    = 24;

    logic       i_clk = 1'b0;
    logic       i_rst_n;
    logic       start;
    logic       busy;
    logic       i_action;
    logic [2:0] i_rect_col;
    logic [2:0] i_rect_row;
    logic [3:0] i_rect_width;
    logic [3:0] i_rect_height;
    logic       i_cfg_we;
    logic [0:0] i_cfg_idx;
    logic [3:0] i_cfg_data;
    logic       o_valid;
    logic [2:0] o_cell_col;
    logic [2:0] o_cell_row;
    logic [3:0] o_span_width;
    logic [3:0] o_span_height;
    logic [2:0] o_status;
    logic       o_last;

    int         miscompares;
    int         replies_due;
    bit         burst;
    int         quiet;

    bit [3:0]   phase_cols [7] = '{4'd8, 4'd1, 4'd8, 4'd1, 4'd0, 4'd15, 4'd5};
    bit [3:0]   phase_rows [7] = '{4'd8, 4'd1, 4'd1, 4'd8, 4'd15, 4'd0, 4'd3};

    grid_rectangle_occupancy_allocator u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_action      (i_action),
        .i_rect_col    (i_rect_col),
        .i_rect_row    (i_rect_row),
        .i_rect_width  (i_rect_width),
        .i_rect_height (i_rect_height),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .o_valid       (o_valid),
        .o_cell_col    (o_cell_col),
        .o_cell_row    (o_cell_row),
        .o_span_width  (o_span_width),
        .o_span_height (o_span_height),
        .o_status      (o_status),
        .o_last        (o_last)
    );

    grid_rectangle_occupancy_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (start),
        .i_busy        (busy),
        .i_sweep       (i_action),
        .i_rect_col    (i_rect_col),
        .i_rect_row    (i_rect_row),
        .i_rect_width  (i_rect_width),
        .i_rect_height (i_rect_height),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_valid       (o_valid),
        .i_cell_col    (o_cell_col),
        .i_cell_row    (o_cell_row),
        .i_span_width  (o_span_width),
        .i_span_height (o_span_height),
        .i_status      (o_status),
        .i_last        (o_last),
        .o_miscompares (miscompares),
        .o_replies_due (replies_due)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || (start && !busy) || o_valid) quiet = 0;
            else quiet++;
        end
        $display("grid_rectangle_occupancy_allocator: mismatch");
        $finish;
    end

    function automatic int usable_span(input bit [3:0] v, input int limit);
        if (v == 4'd0) return 1;
        if (int'(v) > limit) return limit;
        return int'(v);
    endfunction

    task automatic run_cmd(input logic act, input logic [2:0] col, input logic [2:0] row,
                           input logic [3:0] w, input logic [3:0] h);
        int gap;
        int roll;
        roll = $urandom_range(0, 99);
        if (burst || roll < 45) gap = 0;
        else if (roll < 90) gap = $urandom_range(1, 3);
        else gap = $urandom_range(8, 40);
        if (gap != 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start         <= 1'b1;
        i_action      <= act;
        i_rect_col    <= col;
        i_rect_row    <= row;
        i_rect_width  <= w;
        i_rect_height <= h;
        do @(posedge i_clk); while (busy);
    endtask

    // drain all beats and let the sequencer settle before touching the grid size
    task automatic set_grid(input bit [3:0] cols, input bit [3:0] rows);
        start <= 1'b0;
        @(posedge i_clk);
        while (replies_due != 0 || busy) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_GRID_COLS;
        i_cfg_data <= cols;
        @(posedge i_clk);
        i_cfg_idx  <= CFG_GRID_ROWS;
        i_cfg_data <= rows;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    initial begin
        int       ph;
        int       k;
        int       roll;
        int       ncols;
        int       nrows;
        int       w;
        int       h;
        bit [3:0] cfg_c;
        bit [3:0] cfg_r;
        i_rst_n       <= 1'b0;
        start         <= 1'b0;
        i_action      <= ACT_PROPOSE;
        i_rect_col    <= 3'd0;
        i_rect_row    <= 3'd0;
        i_rect_width  <= 4'd0;
        i_rect_height <= 4'd0;
        i_cfg_we      <= 1'b0;
        i_cfg_idx     <= CFG_GRID_COLS;
        i_cfg_data    <= 4'd0;
        burst = 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset grid 8 x 8
        run_cmd(ACT_PROPOSE, 3'd0, 3'd0, 4'd8, 4'd8);
        run_cmd(ACT_FINISH,  3'd0, 3'd0, 4'd0, 4'd0);
        run_cmd(ACT_PROPOSE, 3'd7, 3'd7, 4'd1, 4'd1);
        run_cmd(ACT_PROPOSE, 3'd7, 3'd7, 4'd1, 4'd1);
        run_cmd(ACT_PROPOSE, 3'd0, 3'd0, 4'd0, 4'd1);
        run_cmd(ACT_PROPOSE, 3'd0, 3'd0, 4'd1, 4'd0);
        run_cmd(ACT_PROPOSE, 3'd7, 3'd0, 4'd2, 4'd1);
        run_cmd(ACT_PROPOSE, 3'd0, 3'd7, 4'd1, 4'd2);
        run_cmd(ACT_PROPOSE, 3'd5, 3'd5, 4'd15, 4'd15);
        run_cmd(ACT_PROPOSE, 3'd0, 3'd0, 4'd3, 4'd2);
        run_cmd(ACT_PROPOSE, 3'd2, 3'd1, 4'd2, 4'd2);
        run_cmd(ACT_PROPOSE, 3'd3, 3'd0, 4'd5, 4'd8);
        run_cmd(ACT_PROPOSE, 3'd3, 3'd0, 4'd4, 4'd8);
        run_cmd(ACT_FINISH,  3'd7, 3'd7, 4'd15, 4'd15);
        run_cmd(ACT_PROPOSE, 3'd6, 3'd6, 4'd2, 4'd2);
        // shrink grid: occupied cells outside are not swept but still cleared
        set_grid(4'd4, 4'd4);
        run_cmd(ACT_PROPOSE, 3'd3, 3'd3, 4'd1, 4'd1);
        run_cmd(ACT_PROPOSE, 3'd4, 3'd0, 4'd1, 4'd1);
        run_cmd(ACT_FINISH,  3'd0, 3'd0, 4'd0, 4'd0);
        set_grid(4'd8, 4'd8);
        run_cmd(ACT_FINISH,  3'd0, 3'd0, 4'd0, 4'd0);
        // out-of-range register values clamp
        set_grid(4'd0, 4'd15);
        run_cmd(ACT_PROPOSE, 3'd0, 3'd0, 4'd1, 4'd8);
        run_cmd(ACT_FINISH,  3'd0, 3'd0, 4'd0, 4'd0);
        set_grid(4'd15, 4'd0);
        run_cmd(ACT_PROPOSE, 3'd0, 3'd0, 4'd8, 4'd1);
        run_cmd(ACT_PROPOSE, 3'd1, 3'd0, 4'd1, 4'd1);
        run_cmd(ACT_FINISH,  3'd0, 3'd0, 4'd0, 4'd0);
        run_cmd(ACT_FINISH,  3'd0, 3'd0, 4'd0, 4'd0);

        for (ph = 0; ph < N_PHASES; ph++) begin
            if (ph < 7) begin
                cfg_c = phase_cols[ph];
                cfg_r = phase_rows[ph];
            end else begin
                cfg_c = 4'($urandom_range(0, 15));
                cfg_r = 4'($urandom_range(0, 15));
            end
            set_grid(cfg_c, cfg_r);
            ncols = usable_span(cfg_c, GRO_MAX_COLS);
            nrows = usable_span(cfg_r, GRO_MAX_ROWS);
            for (k = 0; k < PHASE_ITEMS; k++) begin
                if (k % 8 == 0) burst = ($urandom_range(0, 2) == 0);
                roll = $urandom_range(0, 99);
                if (roll < 8) begin
                    run_cmd(ACT_FINISH, 3'($urandom), 3'($urandom), 4'($urandom),
                            4'($urandom));
                end else if (roll < 20) begin
                    run_cmd(ACT_PROPOSE, 3'($urandom), 3'($urandom),
                            4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)));
                end else begin
                    // in-bounds proposal, mostly small so placements keep happening
                    if ($urandom_range(0, 3) == 0) w = $urandom_range(1, ncols);
                    else w = $urandom_range(1, (ncols < 3) ? ncols : 3);
                    if ($urandom_range(0, 3) == 0) h = $urandom_range(1, nrows);
                    else h = $urandom_range(1, (nrows < 3) ? nrows : 3);
                    run_cmd(ACT_PROPOSE, 3'($urandom_range(0, ncols - w)),
                            3'($urandom_range(0, nrows - h)), 4'(w), 4'(h));
                end
            end
        end

        start <= 1'b0;
        @(posedge i_clk);
        while (replies_due != 0) @(posedge i_clk);
        repeat (16) @(posedge i_clk);
        if (miscompares == 0 && replies_due == 0) begin
            $display("grid_rectangle_occupancy_allocator: match");
        end else begin
            $display("grid_rectangle_occupancy_allocator: mismatch");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/gro_pkg.sv
hdl/gro_useq.sv
hdl/gro_dp.sv
hdl/grid_rectangle_occupancy_allocator.sv
dv/grid_rectangle_occupancy_checker.sv
dv/tb_grid_rectangle_occupancy_allocator.sv
